// ===== rtl/core/bvt_pkg.sv =====
package bvt_pkg;

    // Table geometry
    localparam int NUM_ACTIONS = 16;
    localparam int IDX_W       = $clog2(NUM_ACTIONS);
    localparam int CNT_W       = $clog2(NUM_ACTIONS + 1);

    // Fixed field widths
    localparam int ACT_W   = 4;
    localparam int EST_W   = 16;
    localparam int ALPHA_W = 16;
    localparam int NACT_W  = 5;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;

    // Register reset values
    localparam logic [ALPHA_W-1:0]      LEARNING_RATE_RST    = 16'd6554;
    localparam logic [NACT_W-1:0]       ACTIVE_ACTIONS_RST   = 5'd16;
    localparam logic signed [EST_W-1:0] INITIAL_ESTIMATE_RST = 16'sd0;

    // Register indexes
    localparam logic [CIDX_W-1:0] CFG_LEARNING_RATE    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_ACTIVE_ACTIONS   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_INITIAL_ESTIMATE = 2'd2;

endpackage

// ===== rtl/core/bvt_ram.sv =====
module bvt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/bandit_value_table_ema_core.sv =====
// Action-value table with moving-average update and best / runner-up search.
// Input channel s_*: one request carries action, reward and restart. The
// action's estimate moves toward the reward by alpha*(reward-est), saturated,
// alpha Q0.16; restart sets the whole table to initial_estimate instead.
// Result channel m_*: one result per request with the new estimate, the
// indices of the largest and second largest active estimates, and a flag for
// an action outside the active range (no update, estimate reported as 0).
// Configuration: cfg_wr_en / cfg_index / cfg_wdata, to be written by the
// user while idle; the block does not enforce it. A request reads the
// action's estimate, forms the product, writes the update, then reads each
// of the n active entries for the search (n: active count clamped to 2..16);
// no new request is taken before the result is registered. The single read
// port of the estimate RAM serializes the update read and the entry reads.
// A finished result sits in the output register; while the receiver stalls
// the block takes a new request and works it up to the result, then holds.
// Reset: control registers to their defaults and all entries read as zero at
// once through per-entry valid bits; a restart clears them on acceptance.
module bandit_value_table_ema_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [bvt_pkg::CIDX_W-1:0]        cfg_index,
    input  logic [bvt_pkg::CFG_W-1:0]         cfg_wdata,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bvt_pkg::ACT_W-1:0]         s_action,
    input  logic signed [bvt_pkg::EST_W-1:0]  s_reward,
    input  logic                              s_restart,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [bvt_pkg::EST_W-1:0]  m_updated_estimate,
    output logic [bvt_pkg::ACT_W-1:0]         m_best_action,
    output logic [bvt_pkg::ACT_W-1:0]         m_runner_up_action,
    output logic                              m_bad_action
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,
        ST_MULT  = 7'b0000100,
        ST_WRITE = 7'b0001000,
        ST_SCAN  = 7'b0010000,
        ST_DRAIN = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [bvt_pkg::ALPHA_W-1:0]      alpha_reg;
    logic [bvt_pkg::NACT_W-1:0]       nact_reg;
    logic signed [bvt_pkg::EST_W-1:0] init_est_reg;

    // request registers
    logic [bvt_pkg::ACT_W-1:0]        act_reg;
    logic signed [bvt_pkg::EST_W-1:0] reward_reg;
    logic                             restart_reg;
    logic                             bad_reg;
    logic [bvt_pkg::CNT_W-1:0]        n_reg;

    // table state beside the RAM
    logic [bvt_pkg::NUM_ACTIONS-1:0]  vld_reg;
    logic signed [bvt_pkg::EST_W-1:0] fill_reg;

    // update datapath
    logic signed [bvt_pkg::EST_W-1:0] est_reg;
    logic signed [33:0]               prod_reg;
    logic signed [bvt_pkg::EST_W-1:0] result_reg;

    // search
    logic [bvt_pkg::CNT_W-1:0]        cnt_reg;
    logic                             pend_reg;
    logic [bvt_pkg::IDX_W-1:0]        pidx_reg;
    logic [bvt_pkg::IDX_W-1:0]        best_reg, sec_reg;
    logic signed [bvt_pkg::EST_W-1:0] best_val_reg, sec_val_reg;
    logic                             sec_vld_reg;

    // output register
    logic                             m_valid_reg;
    logic signed [bvt_pkg::EST_W-1:0] m_est_reg;
    logic [bvt_pkg::ACT_W-1:0]        m_best_reg, m_sec_reg;
    logic                             m_bad_reg;

    // RAM ports
    logic                             ram_we, ram_re;
    logic [bvt_pkg::IDX_W-1:0]        ram_waddr, ram_raddr;
    logic [bvt_pkg::EST_W-1:0]        ram_wdata, ram_rdata;

    logic [bvt_pkg::CNT_W-1:0]        n_eff;
    logic                             bad_in;
    logic [bvt_pkg::IDX_W-1:0]        act_idx;
    logic signed [bvt_pkg::EST_W-1:0] rd_est, scan_val;
    logic signed [16:0]               diff;
    logic signed [16:0]               alpha_s;
    logic signed [17:0]               delta;
    logic signed [18:0]               sum;
    logic signed [bvt_pkg::EST_W-1:0] sat_est;
    logic                             accept, out_free, scan_last;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign act_idx   = bvt_pkg::IDX_W'(act_reg);
    assign scan_last = (cnt_reg == n_reg - bvt_pkg::CNT_W'(1));

    // clamp of the active count and range check of the action
    always_comb begin
        if (nact_reg < bvt_pkg::NACT_W'(2)) begin
            n_eff = bvt_pkg::CNT_W'(2);
        end else if (32'(nact_reg) > 32'(bvt_pkg::NUM_ACTIONS)) begin
            n_eff = bvt_pkg::CNT_W'(bvt_pkg::NUM_ACTIONS);
        end else begin
            n_eff = bvt_pkg::CNT_W'(nact_reg);
        end
        bad_in = 32'(s_action) >= 32'(n_eff);
    end

    // entries never written since reset or restart read as the fill value
    assign rd_est   = vld_reg[act_idx] ? $signed(ram_rdata) : fill_reg;
    assign scan_val = vld_reg[pidx_reg] ? $signed(ram_rdata) : fill_reg;

    // product stage operands
    assign diff    = 17'(reward_reg) - 17'(rd_est);
    assign alpha_s = $signed({1'b0, alpha_reg});

    // shift (floor) and saturate
    always_comb begin
        delta = $signed(prod_reg[33:16]);
        sum   = 19'(est_reg) + 19'(delta);
        if (sum > 19'sd32767) begin
            sat_est = 16'sh7fff;
        end else if (sum < -19'sd32768) begin
            sat_est = 16'sh8000;
        end else begin
            sat_est = bvt_pkg::EST_W'(sum);
        end
    end

    // RAM access
    always_comb begin
        ram_we    = (state_reg == ST_WRITE) && !restart_reg && !bad_reg;
        ram_waddr = act_idx;
        ram_wdata = sat_est;
        ram_re    = (state_reg == ST_READ) || (state_reg == ST_SCAN);
        ram_raddr = (state_reg == ST_SCAN) ? cnt_reg[bvt_pkg::IDX_W-1:0] : act_idx;
    end

    bvt_ram #(
        .WIDTH (bvt_pkg::EST_W),
        .DEPTH (bvt_pkg::NUM_ACTIONS)
    ) u_est_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_READ;
            ST_READ:  state_next = ST_MULT;
            ST_MULT:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_SCAN;
            ST_SCAN:  if (scan_last) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            alpha_reg    <= bvt_pkg::LEARNING_RATE_RST;
            nact_reg     <= bvt_pkg::ACTIVE_ACTIONS_RST;
            init_est_reg <= bvt_pkg::INITIAL_ESTIMATE_RST;
            vld_reg      <= '0;
            fill_reg     <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    bvt_pkg::CFG_LEARNING_RATE:    alpha_reg    <= cfg_wdata;
                    bvt_pkg::CFG_ACTIVE_ACTIONS:   nact_reg     <= cfg_wdata[bvt_pkg::NACT_W-1:0];
                    bvt_pkg::CFG_INITIAL_ESTIMATE: init_est_reg <= $signed(cfg_wdata);
                    default: ;
                endcase
            end
            // restart empties the table when its request is accepted
            if (accept && s_restart) begin
                vld_reg  <= '0;
                fill_reg <= init_est_reg;
            end else if (ram_we) begin
                vld_reg[act_idx] <= 1'b1;
            end
            pend_reg <= (state_reg == ST_SCAN);
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg     <= s_action;
            reward_reg  <= s_reward;
            restart_reg <= s_restart;
            bad_reg     <= bad_in;
            n_reg       <= n_eff;
        end
        if (state_reg == ST_MULT) begin
            est_reg  <= rd_est;
            prod_reg <= 34'(diff) * 34'(alpha_s);
        end
        if (state_reg == ST_WRITE) begin
            cnt_reg <= '0;
            if (bad_reg) begin
                result_reg <= '0;
            end else if (restart_reg) begin
                result_reg <= fill_reg;
            end else begin
                result_reg <= sat_est;
            end
        end
        if (state_reg == ST_SCAN) begin
            cnt_reg  <= cnt_reg + bvt_pkg::CNT_W'(1);
            pidx_reg <= cnt_reg[bvt_pkg::IDX_W-1:0];
        end
        // running best and runner-up, lowest index kept on ties
        if (pend_reg) begin
            if (pidx_reg == '0) begin
                best_reg     <= pidx_reg;
                best_val_reg <= scan_val;
                sec_vld_reg  <= 1'b0;
            end else if (scan_val > best_val_reg) begin
                sec_reg      <= best_reg;
                sec_val_reg  <= best_val_reg;
                sec_vld_reg  <= 1'b1;
                best_reg     <= pidx_reg;
                best_val_reg <= scan_val;
            end else if (!sec_vld_reg || scan_val > sec_val_reg) begin
                sec_reg     <= pidx_reg;
                sec_val_reg <= scan_val;
                sec_vld_reg <= 1'b1;
            end
        end
        if (state_reg == ST_DONE && out_free) begin
            m_est_reg  <= result_reg;
            m_best_reg <= bvt_pkg::ACT_W'(best_reg);
            m_sec_reg  <= bvt_pkg::ACT_W'(sec_reg);
            m_bad_reg  <= bad_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_updated_estimate = m_est_reg;
    assign m_best_action      = m_best_reg;
    assign m_runner_up_action = m_sec_reg;
    assign m_bad_action       = m_bad_reg;

endmodule
